// ===== hdl/pcm24_lsb_sync_crc_block_checker_unit_defines.svh =====
// assertion macros used by the checker core rtl
`ifndef PCM24_LSB_SYNC_CRC_BLOCK_CHECKER_UNIT_DEFINES_SVH
`define PCM24_LSB_SYNC_CRC_BLOCK_CHECKER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked on every rising clock edge outside reset
`define PCM24CRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pcm24crc assertion failed");
// checked on every rising clock edge, reset included
`define PCM24CRC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("pcm24crc assertion failed");
`else
`define PCM24CRC_ASSERT(lbl, clk, rst_n, prop)
`define PCM24CRC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hdl/pcm24crc_pkg.sv =====
package pcm24crc_pkg;

    localparam int unsigned SAMPLE_W = 24;
    localparam int unsigned LEN_W    = 13;
    localparam int unsigned DEPTH_W  = 4;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned HDR_LEN  = 16;

    localparam int unsigned MAX_BLOCK_LENGTH_DEF = 4096;

    localparam logic [CRC_W-1:0]   CRC_POLY       = 16'h1021;
    localparam logic [7:0]         HDR_LOW_MASK   = 8'hFD;
    localparam logic [11:0]        RAW_LEN_SHORT  = 12'h3D0;
    localparam logic [LEN_W-1:0]   LEN_SHORT      = 13'd1000;
    localparam logic [LEN_W-1:0]   LEN_OFFSET     = 13'd16;
    localparam logic [DEPTH_W-1:0] DEPTH_CODE_LIM = 4'd12;
    localparam logic [DEPTH_W-1:0] DEPTH_BASE     = 4'd14;

    typedef enum logic [2:0] {
        ST_VALID        = 3'd0,
        ST_SYNC_MISSING = 3'd1,
        ST_BAD_DEPTH    = 3'd2,
        ST_RESERVED_SET = 3'd3,
        ST_CRC_MISMATCH = 3'd4,
        ST_ABORTED      = 3'd5
    } t_status;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                start_req;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [LEN_W-1:0]   block_length;
        logic [DEPTH_W-1:0] lsb_depth;
        logic [CRC_W-1:0]   stored_crc;
        logic [CRC_W-1:0]   computed_crc;
    } t_out_item;

endpackage

// ===== hdl/pcm24crc_in_reg.sv =====
module pcm24crc_in_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pcm24crc_pkg::t_in_item i_in_data,
    output logic                  o_item_valid,
    output pcm24crc_pkg::t_in_item o_item,
    input  logic                  i_advance
);

    logic                   r_valid;
    pcm24crc_pkg::t_in_item r_item;

    // slot frees up when the held beat moves on this cycle
    assign o_in_ready   = !r_valid || i_advance;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_data;
        end
    end

endmodule

// ===== hdl/pcm24crc_crc16.sv =====
module pcm24crc_crc16 (
    input  logic [pcm24crc_pkg::CRC_W-1:0]    i_crc,
    input  logic [pcm24crc_pkg::SAMPLE_W-1:0] i_word,
    output logic [pcm24crc_pkg::CRC_W-1:0]    o_crc
);

    // msb-first crc over one byte
    function automatic logic [pcm24crc_pkg::CRC_W-1:0] crc_byte(
        input logic [pcm24crc_pkg::CRC_W-1:0] crc,
        input logic [7:0]                     data
    );
        logic [pcm24crc_pkg::CRC_W-1:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[pcm24crc_pkg::CRC_W-1]) begin
                c = {c[pcm24crc_pkg::CRC_W-2:0], 1'b0} ^ pcm24crc_pkg::CRC_POLY;
            end else begin
                c = {c[pcm24crc_pkg::CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    logic [pcm24crc_pkg::CRC_W-1:0] crc_b0;
    logic [pcm24crc_pkg::CRC_W-1:0] crc_b1;

    // low byte first
    assign crc_b0 = crc_byte(i_crc, i_word[7:0]);
    assign crc_b1 = crc_byte(crc_b0, i_word[15:8]);
    assign o_crc  = crc_byte(crc_b1, i_word[23:16]);

endmodule

// ===== hdl/pcm24crc_core.sv =====
`include "pcm24_lsb_sync_crc_block_checker_unit_defines.svh"

module pcm24crc_core #(
    parameter int unsigned MAX_BLOCK_LENGTH = pcm24crc_pkg::MAX_BLOCK_LENGTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_item_valid,
    input  pcm24crc_pkg::t_in_item  i_item,
    output logic                    o_advance,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output pcm24crc_pkg::t_out_item o_out_data
);

    localparam int unsigned LW = pcm24crc_pkg::LEN_W;
    localparam int unsigned DW = pcm24crc_pkg::DEPTH_W;
    localparam int unsigned CW = pcm24crc_pkg::CRC_W;
    localparam int unsigned HL = pcm24crc_pkg::HDR_LEN;
    localparam logic [LW-1:0] MAX_LEN   = LW'(MAX_BLOCK_LENGTH);
    localparam logic [LW-1:0] HDR_LAST  = LW'(HL - 1);
    localparam logic [LW-1:0] HDR_COUNT = LW'(HL);

    logic          r_open;
    logic [LW-1:0] r_count;
    logic [CW-1:0] r_crc;
    logic [HL-1:0] r_b1;
    logic [HL-1:0] r_b2;
    logic [LW-1:0] r_len;
    logic [DW-1:0] r_depth;
    logic          r_out_valid;
    pcm24crc_pkg::t_out_item r_out;

    logic          n_open;
    logic [LW-1:0] n_count;
    logic [CW-1:0] n_crc;
    logic [HL-1:0] n_b1;
    logic [HL-1:0] n_b2;
    logic [LW-1:0] n_len;
    logic [DW-1:0] n_depth;
    pcm24crc_pkg::t_out_item n_out;
    logic          emit;

    logic          fire;
    logic          start;
    logic [23:0]   s;
    logic          take;
    logic [LW-1:0] idx;
    logic [CW-1:0] crc_in;
    logic [LW-1:0] len_cur;
    logic [DW-1:0] depth_cur;
    logic          hdr;
    logic          last_hdr;
    logic          fail_sync;
    logic          fail_res;
    logic [7:0]    lo;
    logic [CW-1:0] crc_next;
    logic [LW-1:0] cnt_next;
    logic [HL-1:0] b1_sh;
    logic [HL-1:0] b2_sh;
    logic [11:0]   raw;
    logic [LW-1:0] len_dec;
    logic [LW-1:0] len_sat;
    logic [DW-1:0] code;
    logic          bad_depth;
    logic [LW-1:0] len_eff;
    logic [DW-1:0] depth_eff;
    logic          done;
    logic [CW-1:0] comp;

    assign fire      = i_item_valid && (!r_out_valid || i_out_ready);
    assign o_advance = fire;
    assign start     = i_item.start_req;
    assign s         = i_item.sample;

    // a start on an open block whose sample lacks sync drops the new block
    assign take      = start ? (!r_open || s[0]) : r_open;
    assign idx       = start ? '0 : r_count;
    assign crc_in    = start ? '0 : r_crc;
    assign len_cur   = start ? '0 : r_len;
    assign depth_cur = start ? '0 : r_depth;

    assign hdr       = (idx < HDR_COUNT);
    assign last_hdr  = (idx == HDR_LAST);
    assign fail_sync = hdr && !s[0];
    assign fail_res  = !hdr && (idx[3:0] == 4'd0) && s[0];

    assign lo = hdr ? (s[7:0] & pcm24crc_pkg::HDR_LOW_MASK) : s[7:0];

    pcm24crc_crc16 u_crc (
        .i_crc  (crc_in),
        .i_word ({s[23:8], lo}),
        .o_crc  (crc_next)
    );

    assign cnt_next = idx + LW'(1);
    assign b1_sh    = {r_b1[HL-2:0], s[1]};
    assign b2_sh    = {r_b2[HL-2:0], s[2]};

    // bit2 of header samples 0..7 form the raw length, sample 0 on top
    assign raw     = {b2_sh[HL-1:HL-8], 4'b0000};
    assign len_dec = (raw == pcm24crc_pkg::RAW_LEN_SHORT) ? pcm24crc_pkg::LEN_SHORT
                                                          : {1'b0, raw} + pcm24crc_pkg::LEN_OFFSET;
    assign len_sat = (len_dec > MAX_LEN) ? MAX_LEN : len_dec;

    // depth code from bit2 of samples 12..15
    assign code      = b2_sh[DW-1:0];
    assign bad_depth = (code >= pcm24crc_pkg::DEPTH_CODE_LIM);

    assign len_eff   = last_hdr ? len_sat : len_cur;
    assign depth_eff = last_hdr ? (pcm24crc_pkg::DEPTH_BASE - code) : depth_cur;
    assign done      = (idx >= HDR_LAST) && (cnt_next >= len_eff);
    assign comp      = ~crc_next;

    always_comb begin
        n_open  = r_open;
        n_count = r_count;
        n_crc   = r_crc;
        n_b1    = r_b1;
        n_b2    = r_b2;
        n_len   = r_len;
        n_depth = r_depth;
        n_out   = '0;
        emit    = 1'b0;
        if (fire) begin
            if (start && r_open) begin
                emit               = 1'b1;
                n_out.status       = pcm24crc_pkg::ST_ABORTED;
                n_out.block_length = r_len;
                n_out.lsb_depth    = r_depth;
                n_out.stored_crc   = (r_count >= HDR_COUNT) ? r_b1 : '0;
                n_open             = 1'b0;
            end
            if (take) begin
                n_open  = 1'b1;
                n_count = cnt_next;
                n_crc   = crc_next;
                n_len   = len_eff;
                n_depth = depth_eff;
                if (hdr) begin
                    n_b1 = b1_sh;
                    n_b2 = b2_sh;
                end
                if (fail_sync) begin
                    n_open = 1'b0;
                    if (!emit) begin
                        emit               = 1'b1;
                        n_out.status       = pcm24crc_pkg::ST_SYNC_MISSING;
                        n_out.block_length = len_cur;
                        n_out.lsb_depth    = depth_cur;
                    end
                end else if (fail_res) begin
                    n_open             = 1'b0;
                    emit               = 1'b1;
                    n_out.status       = pcm24crc_pkg::ST_RESERVED_SET;
                    n_out.block_length = len_cur;
                    n_out.lsb_depth    = depth_cur;
                    n_out.stored_crc   = r_b1;
                end else if (last_hdr && bad_depth) begin
                    n_open             = 1'b0;
                    emit               = 1'b1;
                    n_out.status       = pcm24crc_pkg::ST_BAD_DEPTH;
                    n_out.block_length = len_eff;
                    n_out.lsb_depth    = depth_cur;
                    n_out.stored_crc   = b1_sh;
                end else if (done) begin
                    n_open             = 1'b0;
                    emit               = 1'b1;
                    n_out.stored_crc   = last_hdr ? b1_sh : r_b1;
                    n_out.status       = (comp == n_out.stored_crc)
                                         ? pcm24crc_pkg::ST_VALID
                                         : pcm24crc_pkg::ST_CRC_MISMATCH;
                    n_out.block_length = len_eff;
                    n_out.lsb_depth    = depth_eff;
                    n_out.computed_crc = comp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_count     <= '0;
            r_crc       <= '0;
            r_b1        <= '0;
            r_b2        <= '0;
            r_len       <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_open  <= n_open;
            r_count <= n_count;
            r_crc   <= n_crc;
            r_b1    <= n_b1;
            r_b2    <= n_b2;
            r_len   <= n_len;
            r_depth <= n_depth;
            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `PCM24CRC_ASSERT(a_emit_shows, i_clk, i_rst_n, fire && emit |=> r_out_valid)
    `PCM24CRC_ASSERT(a_count_below_len, i_clk, i_rst_n, r_open && (r_count >= HDR_COUNT) |-> r_count < r_len)
    `PCM24CRC_ASSERT(a_len_range, i_clk, i_rst_n, r_open && (r_count >= HDR_COUNT) |-> (r_len >= HDR_COUNT) && (r_len <= MAX_LEN))
    `PCM24CRC_ASSERT(a_depth_range, i_clk, i_rst_n, r_open && (r_count >= HDR_COUNT) |-> (r_depth >= 4'd3) && (r_depth <= pcm24crc_pkg::DEPTH_BASE))
    `PCM24CRC_ASSERT(a_crc_only_final, i_clk, i_rst_n, r_out_valid && (r_out.status != pcm24crc_pkg::ST_VALID) && (r_out.status != pcm24crc_pkg::ST_CRC_MISMATCH) |-> r_out.computed_crc == '0)

endmodule

// ===== hdl/pcm24_lsb_sync_crc_block_checker_unit.sv =====
// framed block checker for a 24-bit pcm stream that carries a sync header and a
// crc-16 (polynomial 0x1021, zero start, inverted result) in the low bits of its
// samples. a beat with start_req set opens a candidate block; the first 16
// samples are the header (bit0 set, length in bit2 of samples 0..7, depth code in
// bit2 of samples 12..15, stored crc in bit1 of samples 0..15, msb first). one
// status beat comes out at the end of the block or at its first failure; an early
// start_req reports the open block as aborted. one input beat is accepted every
// clock cycle while the output side keeps up; a beat passes an input register and
// the combinational crc and header decode logic into the result register, which
// holds its status beat. throughput drops only while a finished status waits for
// i_out_ready, and a beat that gives no status still moves on in that case only
// once the waiting status is taken. there is no clearing pass after reset.
module pcm24_lsb_sync_crc_block_checker_unit #(
    parameter int unsigned MAX_BLOCK_LENGTH = pcm24crc_pkg::MAX_BLOCK_LENGTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  pcm24crc_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output pcm24crc_pkg::t_out_item o_out_data
);

    // beat held between the input register and the check logic
    logic                   item_valid;
    pcm24crc_pkg::t_in_item item;
    // check logic takes the held beat this cycle
    logic                   advance;

    pcm24crc_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_advance    (advance)
    );

    // block state, crc, header decode and the result register
    pcm24crc_core #(
        .MAX_BLOCK_LENGTH (MAX_BLOCK_LENGTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_advance    (advance),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

// ===== dv/tb_pcm24_lsb_sync_crc_block_checker_unit.sv =====
`default_nettype none

module tb_pcm24_lsb_sync_crc_block_checker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pcm24crc_pkg::*;

    // stimulus volume and run guard
    localparam int unsigned ITEMS       = 1450;
    localparam int unsigned TAIL_QUIET  = 150;
    localparam int unsigned DRAIN_WAIT  = 20;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // shapes of stimulus frame, the first few are taken in this order
    typedef enum int unsigned {
        FK_CLEAN,
        FK_LONG_CUT,
        FK_RESERVED,
        FK_CRC_FLIP,
        FK_SYNC_LOSS,
        FK_BAD_DEPTH,
        FK_CUT_SHORT,
        FK_NOISE
    } t_frame_kind;

    // tracks the open block per sample beat and holds the status beats still owed
    class block_check_scoreboard;
        bit [15:0]   crc_acc;
        bit [12:0]   sample_cnt;
        bit [47:0]   hdr_bits;
        bit [12:0]   dec_len;
        bit [3:0]    dec_depth;
        bit          blk_open;
        t_out_item   status_due_q[$];
        int unsigned errors;

        function bit [15:0] crc_update(bit [15:0] crc, bit [7:0] b);
            bit [15:0] c;
            c = crc ^ {b, 8'h00};
            for (int i = 0; i < 8; i++)
                c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            return c;
        endfunction

        function int unsigned hdr_field(int unsigned i);
            return hdr_bits[3*i +: 3];
        endfunction

        // bit1 of the header samples, first sample in the msb
        function bit [15:0] header_crc();
            bit [15:0] v;
            v = '0;
            for (int i = 0; i < HDR_LEN; i++)
                v = {v[14:0], hdr_bits[3*i+1]};
            return v;
        endfunction

        function t_out_item make_status(t_status st, bit [15:0] comp);
            t_out_item r;
            r.status       = st;
            r.block_length = dec_len;
            r.lsb_depth    = dec_depth;
            r.stored_crc   = (sample_cnt >= HDR_LEN) ? header_crc() : '0;
            r.computed_crc = comp;
            return r;
        endfunction

        function bit take_sample(bit [23:0] s, output t_out_item r);
            int unsigned idx, a, b, c, raw, len, code;
            bit [7:0]    lo;
            bit [15:0]   comp;
            idx = sample_cnt;
            lo  = s[7:0];
            if (idx < HDR_LEN) begin
                if (!s[0]) begin
                    blk_open = 1'b0;
                    r = make_status(ST_SYNC_MISSING, '0);
                    return 1'b1;
                end
                hdr_bits[3*idx +: 3] = hdr_bits[3*idx +: 3] | s[2:0];
                lo = lo & HDR_LOW_MASK;
            end else if (idx % HDR_LEN == 0 && s[0]) begin
                blk_open = 1'b0;
                r = make_status(ST_RESERVED_SET, '0);
                return 1'b1;
            end
            crc_acc    = crc_update(crc_update(crc_update(crc_acc, lo), s[15:8]), s[23:16]);
            sample_cnt = 13'(idx + 1);

            if (idx == HDR_LEN - 1) begin
                // length from bit2 of the first eight header samples
                a   = (hdr_field(0) & 4) | ((hdr_field(1) >> 1) & 3);
                b   = ((4 * a) & 'hF8) | (hdr_field(2) & 4) | ((hdr_field(3) >> 1) & 3);
                c   = ((4 * b) & 'h78) | (hdr_field(4) & 4) | ((hdr_field(5) >> 1) & 2)
                      | ((hdr_field(6) & 4) ? 1 : 0);
                raw = ((4 * hdr_field(7)) & 'h10) | (32 * c);
                len = (raw == RAW_LEN_SHORT) ? LEN_SHORT : raw + LEN_OFFSET;
                if (len > MAX_BLOCK_LENGTH_DEF)
                    len = MAX_BLOCK_LENGTH_DEF;
                dec_len = 13'(len);
                code = 0;
                for (int i = 12; i < HDR_LEN; i++)
                    code = (code << 1) | ((hdr_field(i) >> 2) & 1);
                if (code >= DEPTH_CODE_LIM) begin
                    blk_open = 1'b0;
                    r = make_status(ST_BAD_DEPTH, '0);
                    return 1'b1;
                end
                dec_depth = 4'(DEPTH_BASE - code);
            end

            if (idx >= HDR_LEN - 1 && sample_cnt >= dec_len) begin
                comp     = ~crc_acc;
                blk_open = 1'b0;
                r = make_status((comp == header_crc()) ? ST_VALID : ST_CRC_MISMATCH, comp);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_input(t_in_item it);
            t_out_item r, spare;
            bit        got;
            got = 1'b0;
            if (it.start_req) begin
                // an early start reports the open block; the new one never reports here
                if (blk_open) begin
                    r   = make_status(ST_ABORTED, '0);
                    got = 1'b1;
                end
                crc_acc    = '0;
                sample_cnt = '0;
                hdr_bits   = '0;
                dec_len    = '0;
                dec_depth  = '0;
                blk_open   = 1'b1;
                if (got)
                    void'(take_sample(it.sample, spare));
                else
                    got = take_sample(it.sample, r);
            end else if (blk_open) begin
                got = take_sample(it.sample, r);
            end
            if (got)
                status_due_q.insert(status_due_q.size(), r);
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] %s", $time, msg);
        endtask

        task check_status(t_out_item got);
            t_out_item want;
            if (status_due_q.size() == 0) begin
                report($sformatf("status beat with nothing pending: %h", got));
                return;
            end
            want = status_due_q.pop_front();
            if (got.status !== want.status)
                report($sformatf("status: got %0d want %0d", got.status, want.status));
            if (got.block_length !== want.block_length)
                report($sformatf("block_length: got %0d want %0d",
                                 got.block_length, want.block_length));
            if (got.lsb_depth !== want.lsb_depth)
                report($sformatf("lsb_depth: got %0d want %0d", got.lsb_depth, want.lsb_depth));
            if (got.stored_crc !== want.stored_crc)
                report($sformatf("stored_crc: got %h want %h", got.stored_crc, want.stored_crc));
            if (got.computed_crc !== want.computed_crc)
                report($sformatf("computed_crc: got %h want %h",
                                 got.computed_crc, want.computed_crc));
        endtask
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    block_check_scoreboard sb = new();

    // idling controls, changed per frame by the stimulus
    bit          idle_en    = 1'b1;
    int unsigned gap_rate   = 4;
    int unsigned stall_rate = 4;
    int unsigned beats_sent = 0;
    int unsigned cycles     = 0;

    t_in_item frame_q[$];

    pcm24_lsb_sync_crc_block_checker_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // 10 ns clock
    always #5 clk = ~clk;

    // run guard: a hung handshake or a lost status ends here
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one sample beat, with an optional idle burst in front of it
    task automatic send_beat(input t_in_item it);
        if (idle_en && gap_rate != 0 && $urandom_range(0, gap_rate - 1) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(it);
        beats_sent++;
    endtask

    task automatic send_frame(input int unsigned upto);
        for (int i = 0; i < upto && i < frame_q.size(); i++)
            send_beat(frame_q[i]);
    endtask

    function automatic void set_bit(int unsigned k, int unsigned b, bit v);
        t_in_item t;
        t = frame_q[k];
        t.sample[b] = v;
        frame_q[k] = t;
    endfunction

    // well-formed block: sync lsb in the header, length and depth code in bit2,
    // reserved lsb clear every 16th sample, then the inverted crc in header bit1
    function automatic void build_frame(bit [7:0] len_code, bit [3:0] depth_code);
        int unsigned len;
        bit [15:0]   crc;
        bit [7:0]    lo;
        t_in_item    it;
        frame_q.delete();
        len = ({len_code, 4'h0} == RAW_LEN_SHORT) ? LEN_SHORT : HDR_LEN * (len_code + 1);
        crc = '0;
        for (int i = 0; i < len; i++) begin
            it.sample    = 24'($urandom);
            it.start_req = (i == 0);
            if (i < HDR_LEN) begin
                it.sample[0] = 1'b1;
                it.sample[1] = 1'b0;
                if (i < 8)
                    it.sample[2] = len_code[7 - i];
                else if (i >= 12)
                    it.sample[2] = depth_code[15 - i];
                lo = it.sample[7:0] & HDR_LOW_MASK;
            end else begin
                if (i % HDR_LEN == 0)
                    it.sample[0] = 1'b0;
                lo = it.sample[7:0];
            end
            crc = sb.crc_update(crc, lo);
            crc = sb.crc_update(crc, it.sample[15:8]);
            crc = sb.crc_update(crc, it.sample[23:16]);
            frame_q.insert(frame_q.size(), it);
        end
        // bit1 is masked out of the header crc, so filling it in changes nothing
        crc = ~crc;
        for (int i = 0; i < HDR_LEN; i++)
            set_bit(i, 1, crc[15 - i]);
    endfunction

    // result side: random stall bursts, compared beat by beat
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_status(out_data);
            if (!idle_en)
                stall_left = 0;
            else if (stall_left == 0 && $urandom_range(0, 49) < stall_rate)
                stall_left = $urandom_range(1, 19);
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_frame_kind kind;
        bit [7:0]    len_code;
        bit [3:0]    depth_code;
        int unsigned frames, k, pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // samples while idle are dropped without a status
        send_beat(t_in_item'{sample: 24'hFFFFFF, start_req: 1'b0});
        send_beat(t_in_item'{sample: 24'h000000, start_req: 1'b0});
        // start beat without the sync lsb fails at once
        send_beat(t_in_item'{sample: 24'h000000, start_req: 1'b1});
        // longest length code with the top depth code: rejected depth, 4096 reported
        build_frame(8'hFF, 4'hF);
        send_frame(HDR_LEN);
        // early start that lacks the sync lsb: abort of the old block only
        build_frame(8'h00, 4'h0);
        send_frame(3);
        send_beat(t_in_item'{sample: 24'hFFFFFE, start_req: 1'b1});

        frames = 0;
        while (beats_sent < ITEMS) begin
            if (beats_sent > ITEMS - TAIL_QUIET)
                idle_en = 1'b0;
            case ($urandom_range(0, 3))
                0: begin gap_rate = 0;  stall_rate = 0;  end
                1: begin gap_rate = 3;  stall_rate = 6;  end
                2: begin gap_rate = 10; stall_rate = 2;  end
                default: begin gap_rate = 0; stall_rate = 10; end
            endcase

            if (frames < 5) begin
                kind = t_frame_kind'(frames);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 45)      kind = FK_CLEAN;
                else if (pick < 52) kind = FK_SYNC_LOSS;
                else if (pick < 58) kind = FK_BAD_DEPTH;
                else if (pick < 65) kind = FK_RESERVED;
                else if (pick < 75) kind = FK_CRC_FLIP;
                else if (pick < 85) kind = FK_CUT_SHORT;
                else if (pick < 90) kind = FK_LONG_CUT;
                else                kind = FK_NOISE;
            end

            // mostly short blocks so that many of them complete
            len_code   = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3))
                                                   : 8'($urandom_range(4, 11));
            depth_code = 4'($urandom_range(0, DEPTH_CODE_LIM - 1));

            case (kind)
                FK_CLEAN: begin
                    build_frame(len_code, depth_code);
                    send_frame(frame_q.size());
                end
                FK_LONG_CUT: begin
                    // long or random length codes, sent only through the header and up to 24 more samples
                    case ($urandom_range(0, 2))
                        0: len_code = RAW_LEN_SHORT[11:4];
                        1: len_code = 8'hFF;
                        default: len_code = 8'($urandom_range(0, 255));
                    endcase
                    if (frames == 1)
                        len_code = RAW_LEN_SHORT[11:4];
                    build_frame(len_code, depth_code);
                    send_frame($urandom_range(HDR_LEN, HDR_LEN + 24));
                end
                FK_RESERVED: begin
                    if (len_code == 0)
                        len_code = 8'd1;
                    build_frame(len_code, depth_code);
                    k = HDR_LEN * $urandom_range(1, frame_q.size() / HDR_LEN - 1);
                    set_bit(k, 0, 1'b1);
                    send_frame(k + 1);
                end
                FK_CRC_FLIP: begin
                    build_frame(len_code, depth_code);
                    k    = $urandom_range(0, frame_q.size() - 1);
                    pick = $urandom_range(3, 23);
                    set_bit(k, pick, !frame_q[k].sample[pick]);
                    send_frame(frame_q.size());
                end
                FK_SYNC_LOSS: begin
                    build_frame(len_code, depth_code);
                    k = $urandom_range(0, HDR_LEN - 1);
                    set_bit(k, 0, 1'b0);
                    send_frame(k + 1);
                end
                FK_BAD_DEPTH: begin
                    build_frame(len_code, 4'($urandom_range(DEPTH_CODE_LIM, 15)));
                    send_frame(HDR_LEN);
                end
                FK_CUT_SHORT: begin
                    build_frame(len_code, depth_code);
                    send_frame($urandom_range(1, frame_q.size() - 1));
                end
                default: begin
                    // raw noise, now and then with a start flag
                    repeat ($urandom_range(1, 12))
                        send_beat(t_in_item'{sample: 24'($urandom),
                                             start_req: ($urandom_range(0, 5) == 0)});
                end
            endcase
            frames++;
        end

        in_valid <= 1'b0;
        while (sb.status_due_q.size() != 0) @(posedge clk);
        // let any stray status beat show up before the verdict
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
